@@ rtl/pal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants for the positional array list: capacity, derived widths,
// command and status codes.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int CMD_W    = 2;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int ICNT_W   = 9;

	// common width for position / count compares
	localparam int CMP_W    = 9;

	localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_POS_EMPTY = 3'd4;

	typedef logic [CMP_W-1:0] cmp_t;

endpackage
`default_nettype wire

@@ rtl/positional_array_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list
// Packed list of signed 32-bit words with read, insert and remove by
// position, kept in a single-port-write, registered-read slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd, position and value and raise start while busy is low; the
//   request is taken at that clock edge and busy rises on the next cycle.
//   Exactly one result follows: done is high for one cycle with status,
//   read_value and item_count valid in that cycle. The receiver cannot
//   stall; the result is gone after that cycle.
//   A rejected request, an append or a remove of the last entry goes from
//   the check straight to done; a read first captures the registered
//   memory word; an insert below the count shifts slots up, then writes
//   the new word; any other remove shifts slots down.
//   One request is worked at a time; the next may be accepted in the cycle
//   after done. Shifts move one slot at a time through the single memory
//   read port (read, then write back one place over), with one index
//   counter stepping over the slots.
//   Reset clears the count and the sequencer; slot contents are left as
//   they are, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module positional_array_list (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [pal_pkg::CMD_W-1:0]           cmd,
	input  wire  [pal_pkg::POS_W-1:0]           position,
	input  wire  signed [pal_pkg::DATA_W-1:0]   value,
	output logic                                done,
	output logic [pal_pkg::STATUS_W-1:0]        status,
	output logic signed [pal_pkg::DATA_W-1:0]   read_value,
	output logic [pal_pkg::ICNT_W-1:0]          item_count
);
	import pal_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_RWAIT = 3'd2;
	localparam logic [2:0] S_SHRD  = 3'd3;
	localparam logic [2:0] S_SHWR  = 3'd4;
	localparam logic [2:0] S_INSV  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]              state_q;
	logic [CMD_W-1:0]        cmd_q;
	logic [POS_W-1:0]        pos_q;
	logic [DATA_W-1:0]       val_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        idx_q;
	logic [STATUS_W-1:0]     status_q;
	logic [DATA_W-1:0]       rval_q;

	logic [DATA_W-1:0]       mem [CAPACITY];
	logic [DATA_W-1:0]       rdata_q;
	logic [IDX_W-1:0]        rd_addr;
	logic                    we;
	logic [IDX_W-1:0]        wr_addr;
	logic [DATA_W-1:0]       wr_data;

	cmp_t pos_c;
	cmp_t cnt_c;
	cmp_t idx_c;
	cmp_t cap_c;

	assign pos_c = cmp_t'(pos_q);
	assign cnt_c = cmp_t'(count_q);
	assign idx_c = cmp_t'(idx_q);
	assign cap_c = cmp_t'(CAPACITY);

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		rd_addr = pos_q[IDX_W-1:0];
		we      = 1'b0;
		wr_addr = idx_q;
		wr_data = rdata_q;
		case (state_q)
			S_CHECK: begin
				if (cmd_q == CMD_INSERT && pos_c >= cnt_c && cnt_c < cap_c) begin
					we      = (pos_c < cap_c);
					wr_addr = count_q[IDX_W-1:0];
					wr_data = val_q;
				end
			end
			S_SHRD: begin
				rd_addr = (cmd_q == CMD_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
			end
			S_SHWR: begin
				we = 1'b1;
			end
			S_INSV: begin
				we      = 1'b1;
				wr_addr = pos_q[IDX_W-1:0];
				wr_data = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			status_q <= ST_OK;
			rval_q   <= '0;
			cmd_q    <= CMD_READ;
			pos_q    <= '0;
			val_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= cmd;
						pos_q    <= position;
						val_q    <= value;
						status_q <= ST_OK;
						rval_q   <= '0;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_FIN;
					if (pos_c >= cap_c || !(cmd_q == CMD_READ || cmd_q == CMD_INSERT ||
							cmd_q == CMD_REMOVE)) begin
						status_q <= ST_BAD_POS;
					end else if (cmd_q == CMD_READ) begin
						if (pos_c >= cnt_c) begin
							status_q <= ST_POS_EMPTY;
						end else begin
							state_q <= S_RWAIT;
						end
					end else if (cmd_q == CMD_INSERT) begin
						if (cnt_c >= cap_c) begin
							status_q <= ST_FULL;
						end else if (pos_c >= cnt_c) begin
							count_q <= count_q + 1'b1;
						end else begin
							idx_q   <= count_q[IDX_W-1:0];
							state_q <= S_SHRD;
						end
					end else begin
						if (count_q == '0) begin
							status_q <= ST_EMPTY;
						end else if (pos_c >= cnt_c) begin
							status_q <= ST_POS_EMPTY;
						end else if (pos_c + 1'b1 < cnt_c) begin
							idx_q   <= pos_q[IDX_W-1:0];
							state_q <= S_SHRD;
						end else begin
							// last entry: drop it
							count_q <= count_q - 1'b1;
						end
					end
				end
				S_RWAIT: begin
					rval_q  <= rdata_q;
					state_q <= S_FIN;
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					if (cmd_q == CMD_INSERT) begin
						idx_q <= idx_q - 1'b1;
						if (idx_c - 1'b1 == pos_c) begin
							state_q <= S_INSV;
						end else begin
							state_q <= S_SHRD;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						if (idx_c + 2'd2 >= cnt_c) begin
							count_q <= count_q - 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_SHRD;
						end
					end
				end
				S_INSV: begin
					count_q <= count_q + 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_FIN);
	assign status     = status_q;
	assign read_value = rval_q;
	assign item_count = ICNT_W'(count_q);

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for positional_array_list. A local list model predicts
// status, read word and count for every accepted request. A checker compares
// each done strobe with the oldest prediction. Directed cases cover the empty
// list, front, middle and end inserts, and removes. Random phases then grow,
// shrink and churn the list through empty and full with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
	import pal_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int PHASE_COUNT    = 12;
	localparam int PHASE_ITEMS    = 78;

	typedef enum int {GROW, SHRINK, CHURN} walk_mode_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] read_value;
		logic [ICNT_W-1:0]        item_count;
	} list_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [CMD_W-1:0]         cmd;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] read_value;
	logic [ICNT_W-1:0]        item_count;

	// list model
	logic signed [DATA_W-1:0] list_words [CAPACITY];
	int                       list_count;

	list_result_t             pending_results [$];
	int                       error_count;
	int                       idle_cycles;
	bit                       no_gaps;

	positional_array_list u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.item_count (item_count)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic list_result_t apply_request(input logic [CMD_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] word);
		list_result_t r;
		int           i;
		r.status     = ST_OK;
		r.read_value = '0;
		if (op == CMD_UNUSED || pos >= CAPACITY) begin
			r.status = ST_BAD_POS;
		end else if (op == CMD_READ) begin
			if (pos >= list_count)
				r.status = ST_POS_EMPTY;
			else
				r.read_value = list_words[IDX_W'(pos)];
		end else if (op == CMD_INSERT) begin
			if (list_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else if (pos >= list_count) begin
				list_words[IDX_W'(list_count)] = word;
				list_count++;
			end else begin
				// open a hole at pos
				for (i = list_count; i > pos; i--)
					list_words[IDX_W'(i)] = list_words[IDX_W'(i - 1)];
				list_words[IDX_W'(pos)] = word;
				list_count++;
			end
		end else begin
			if (list_count == 0) begin
				r.status = ST_EMPTY;
			end else if (pos >= list_count) begin
				r.status = ST_POS_EMPTY;
			end else begin
				for (i = pos; i + 1 < list_count; i++)
					list_words[IDX_W'(i)] = list_words[IDX_W'(i + 1)];
				list_count--;
			end
		end
		r.item_count = list_count[ICNT_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		case (r % 5)
			0: pick_word = 32'sh8000_0000;
			1: pick_word = 32'sh7fff_ffff;
			2: pick_word = 32'sh0000_0000;
			3: pick_word = -32'sd1;
			default: pick_word = 32'sd1;
		endcase
		if (r >= 10)
			pick_word = $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] op);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return POS_W'($urandom_range(CAPACITY, 255));
		else if (r < 15 || list_count == 0)
			return POS_W'($urandom_range(0, CAPACITY - 1));
		else if (op == CMD_INSERT || r < 22)
			return POS_W'($urandom_range(0, list_count));
		else
			return POS_W'($urandom_range(0, list_count - 1));
	endfunction

	// hold the request until taken, then record its prediction
	task automatic send_request(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] word, input int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd      = op;
		position = pos;
		value    = word;
		start    = 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(apply_request(op, pos, word));
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic test_empty_list();
		send_request(CMD_READ, 8'd0, 32'sd5, 0);
		send_request(CMD_REMOVE, 8'd0, 32'sd0, 0);
		send_request(CMD_REMOVE, 8'd255, 32'sd0, 1);
		send_request(CMD_READ, POS_W'(CAPACITY), 32'sd0, 0);
		send_request(CMD_UNUSED, 8'd0, -32'sd1, 0);
		drain();
	endtask

	task automatic test_insert_cases();
		int p;
		// valid position past the count appends at slot 0
		send_request(CMD_INSERT, POS_W'(CAPACITY - 1), 32'sh7fff_ffff, 0);
		send_request(CMD_INSERT, 8'd0, 32'sh8000_0000, 0);
		send_request(CMD_INSERT, 8'd1, -32'sd1, 2);
		send_request(CMD_INSERT, 8'd3, 32'sd0, 0);
		send_request(CMD_INSERT, 8'd255, 32'sh5555_aaaa, 0);
		send_request(CMD_INSERT, POS_W'(CAPACITY), 32'sh1234_5678, 0);
		for (p = 0; p < 4; p++)
			send_request(CMD_READ, POS_W'(p), 32'sd0, 0);
		drain();
	endtask

	task automatic test_remove_cases();
		send_request(CMD_REMOVE, 8'd4, 32'sd0, 0);
		send_request(CMD_REMOVE, 8'd3, 32'sd0, 0);
		send_request(CMD_REMOVE, 8'd0, 32'sd0, 3);
		send_request(CMD_READ, 8'd0, 32'sd0, 0);
		send_request(CMD_READ, 8'd1, 32'sd0, 0);
		send_request(CMD_REMOVE, 8'd200, 32'sd0, 0);
		send_request(CMD_REMOVE, 8'd1, 32'sd0, 0);
		send_request(CMD_REMOVE, 8'd0, 32'sd0, 0);
		send_request(CMD_REMOVE, 8'd0, 32'sd0, 0);
		drain();
	endtask

	task automatic test_random_walk();
		walk_mode_t       mode;
		logic [CMD_W-1:0] op;
		int               ph;
		int               n;
		int               r;
		int               ins_pct;
		int               rem_pct;
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			mode    = walk_mode_t'(ph % 3);
			no_gaps = (ph % 4 == 3);
			case (mode)
				GROW: begin
					ins_pct = 65;
					rem_pct = 15;
				end
				SHRINK: begin
					ins_pct = 15;
					rem_pct = 65;
				end
				default: begin
					ins_pct = 35;
					rem_pct = 30;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					op = CMD_UNUSED;
				else if (r < 3 + ins_pct)
					op = CMD_INSERT;
				else if (r < 3 + ins_pct + rem_pct)
					op = CMD_REMOVE;
				else
					op = CMD_READ;
				send_request(op, pick_position(op), pick_word(), pick_gap());
			end
			// let every result land before the next phase
			drain();
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("done with no request outstanding");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value, read_value);
					error_count++;
				end
				if (item_count !== want.item_count) begin
					$error("item_count: expected %0d, got %0d", want.item_count, item_count);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("[positional_array_list] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = CMD_READ;
		position    = '0;
		value       = '0;
		list_count  = 0;
		error_count = 0;
		idle_cycles = 0;
		no_gaps     = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_list();
		test_insert_cases();
		test_remove_cases();
		test_random_walk();

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("[positional_array_list] OK");
		else
			$display("[positional_array_list] ERROR");
		$finish;
	end

endmodule

@@ positional_array_list.f @@
rtl/pal_pkg.sv
rtl/positional_array_list.sv
tb/sv/tb_top.sv
